[rtl/core/lprr_pkg.sv]
// Shared types, codes and constants for the length-prefixed record ring.
// Used by every module of the block; depends on nothing.
package lprr_pkg;

   localparam int RING_DEPTH_DEF = 4096;
   localparam int RING_MIN       = 4;
   localparam int QUEUE_DEPTH    = 2;
   localparam int BYTES_USED_W   = 12;
   localparam int RING_BYTES_W   = 13;
   localparam logic [RING_BYTES_W-1:0] RING_BYTES_RESET = 13'd4096;

   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_DATA  = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_DATA  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_NOP   = 2'd3;

   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_DISABLED = 3'd1;
   localparam logic [2:0] STATUS_BAD_LEN  = 3'd2;
   localparam logic [2:0] STATUS_NO_ROOM  = 3'd3;
   localparam logic [2:0] STATUS_NO_OPEN  = 3'd4;
   localparam logic [2:0] STATUS_EMPTY    = 3'd5;
   localparam logic [2:0] STATUS_PENDING  = 3'd6;

   localparam logic [2:0] ADDR_LOG_ENABLE = 3'd0;
   localparam logic [2:0] ADDR_RING_BYTES = 3'd4;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] rec_len;
      logic [7:0] byte_in;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]              status;
      logic [7:0]              byte_out;
      logic [7:0]              record_len;
      logic                    last;
      logic [BYTES_USED_W-1:0] bytes_used;
   } rsp_payload_type;

   typedef struct packed {
      logic [1:0] op;
      logic       len_zero;
      logic [7:0] rec_len;
      logic [7:0] byte_in;
   } queue_entry_type;

endpackage

[rtl/core/lprr_front.sv]
// Front end: accepts requests and classifies them into queue entries.
// Depends on lprr_pkg.
module lprr_front
   import lprr_pkg::*;
(
   input  req_payload_type req_data,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            push_valid,
   input  logic            push_ready,
   output queue_entry_type push_entry
);

   always_comb begin
      push_entry.rec_len  = req_data.rec_len;
      push_entry.byte_in  = req_data.byte_in;
      push_entry.len_zero = (req_data.rec_len == 8'd0);
      unique case (req_data.kind)
         KIND_START: push_entry.op = OP_START;
         KIND_DATA:  push_entry.op = OP_DATA;
         KIND_READ:  push_entry.op = OP_READ;
         default:    push_entry.op = OP_NOP;
      endcase
   end

   assign push_valid = req_valid;
   assign req_ready  = push_ready;

endmodule

[rtl/core/lprr_queue.sv]
// Short request queue between the front end and the back end.
// Depends on lprr_pkg.
module lprr_queue
   import lprr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   output logic            push_ready,
   input  queue_entry_type push_entry,
   output logic            pop_valid,
   input  logic            pop_ready,
   output queue_entry_type pop_entry
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   queue_entry_type slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             do_push, do_pop;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[rtl/core/lprr_back.sv]
// Back end: ring store, write/read pointers, record checks and response register.
// Depends on lprr_pkg.
module lprr_back
   import lprr_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEF,
   localparam int POS_W     = $clog2(RING_DEPTH),
   localparam int SIZE_W    = POS_W + 1
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  queue_entry_type   pop_entry,
   input  logic              log_enable,
   input  logic [SIZE_W-1:0] ring_size,
   input  logic              ring_clear,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_payload_type   rsp_data
);

   localparam int CHK_W = ((SIZE_W > 9) ? SIZE_W : 9) + 1;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_HDR  = 2'd1;
   localparam logic [1:0] S_DATA = 2'd2;

   logic [7:0]        ring_mem [RING_DEPTH];
   logic [7:0]        rd_data_ff;
   logic [1:0]        state_ff,      state_in;
   logic [POS_W-1:0]  write_pos_ff,  write_pos_in;
   logic [POS_W-1:0]  commit_pos_ff, commit_pos_in;
   logic [POS_W-1:0]  read_pos_ff,   read_pos_in;
   logic [POS_W-1:0]  used_ff,       used_in;
   logic [7:0]        write_left_ff, write_left_in;
   logic [7:0]        wr_len_ff,     wr_len_in;
   logic [7:0]        read_left_ff,  read_left_in;
   logic [7:0]        read_len_ff,   read_len_in;
   logic              rsp_valid_ff,  rsp_valid_in;
   rsp_payload_type   rsp_data_ff;
   rsp_payload_type   result;
   logic              res_load;
   logic              out_free;
   logic              mem_we, mem_re;
   logic [POS_W-1:0]  mem_waddr, mem_raddr;
   logic [7:0]        mem_wdata;
   logic [POS_W-1:0]  wp_adv, rp_adv;
   logic [CHK_W-1:0]  room_need;
   logic [31:0]       used_wide;

   function automatic logic [POS_W-1:0] advance(input logic [POS_W-1:0] p,
                                               input logic [SIZE_W-1:0] s);
      logic [SIZE_W-1:0] n;
      n = {1'b0, p} + SIZE_W'(1);
      return (n >= s) ? '0 : n[POS_W-1:0];
   endfunction

   assign wp_adv    = advance(write_pos_ff, ring_size);
   assign rp_adv    = advance(read_pos_ff, ring_size);
   assign room_need = CHK_W'(pop_entry.rec_len) + CHK_W'(2) + CHK_W'(used_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      write_pos_in  = write_pos_ff;
      commit_pos_in = commit_pos_ff;
      read_pos_in   = read_pos_ff;
      used_in       = used_ff;
      write_left_in = write_left_ff;
      wr_len_in     = wr_len_ff;
      read_left_in  = read_left_ff;
      read_len_in   = read_len_ff;
      mem_we        = 1'b0;
      mem_waddr     = write_pos_ff;
      mem_wdata     = pop_entry.byte_in;
      mem_re        = 1'b0;
      mem_raddr     = read_pos_ff;
      res_load      = 1'b0;
      pop_ready     = 1'b0;
      result        = '0;
      result.status = STATUS_OK;

      unique case (state_ff)
         S_IDLE: begin
            if (pop_valid && out_free) begin
               pop_ready = 1'b1;
               unique case (pop_entry.op)
                  OP_START: begin
                     res_load = 1'b1;
                     if (!log_enable) begin
                        result.status = STATUS_DISABLED;
                     end else if (write_left_ff != 8'd0) begin
                        result.status = STATUS_PENDING;
                     end else if (pop_entry.len_zero) begin
                        result.status = STATUS_BAD_LEN;
                     end else if (room_need > CHK_W'(ring_size)) begin
                        result.status = STATUS_NO_ROOM;
                     end else begin
                        mem_we        = 1'b1;
                        mem_wdata     = pop_entry.rec_len;
                        write_pos_in  = wp_adv;
                        write_left_in = pop_entry.rec_len;
                        wr_len_in     = pop_entry.rec_len;
                     end
                  end
                  OP_DATA: begin
                     res_load = 1'b1;
                     if (write_left_ff == 8'd0) begin
                        result.status = STATUS_NO_OPEN;
                     end else begin
                        mem_we        = 1'b1;
                        write_pos_in  = wp_adv;
                        write_left_in = write_left_ff - 8'd1;
                        if (write_left_ff == 8'd1) begin
                           commit_pos_in = wp_adv;
                           used_in       = used_ff + POS_W'(wr_len_ff) + POS_W'(1);
                           result.last   = 1'b1;
                        end
                     end
                  end
                  OP_READ: begin
                     if (read_left_ff == 8'd0 && read_pos_ff == commit_pos_ff) begin
                        res_load      = 1'b1;
                        result.status = STATUS_EMPTY;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = read_pos_ff;
                        state_in  = (read_left_ff == 8'd0) ? S_HDR : S_DATA;
                     end
                  end
                  default: begin
                     res_load = 1'b1;
                  end
               endcase
            end
         end
         S_HDR: begin
            read_pos_in = rp_adv;
            used_in     = used_ff - POS_W'(1);
            read_len_in = rd_data_ff;
            if (rd_data_ff == 8'd0 || rp_adv == commit_pos_ff) begin
               read_left_in  = 8'd0;
               res_load      = 1'b1;
               result.status = STATUS_EMPTY;
               state_in      = S_IDLE;
            end else begin
               read_left_in = rd_data_ff;
               mem_re       = 1'b1;
               mem_raddr    = rp_adv;
               state_in     = S_DATA;
            end
         end
         S_DATA: begin
            read_pos_in       = rp_adv;
            used_in           = used_ff - POS_W'(1);
            read_left_in      = read_left_ff - 8'd1;
            res_load          = 1'b1;
            result.byte_out   = rd_data_ff;
            result.record_len = read_len_ff;
            result.last       = (read_left_ff == 8'd1);
            state_in          = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      used_wide         = 32'(used_in);
      result.bytes_used = used_wide[BYTES_USED_W-1:0];
      rsp_valid_in      = res_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         write_pos_ff  <= '0;
         commit_pos_ff <= '0;
         read_pos_ff   <= '0;
         used_ff       <= '0;
         write_left_ff <= '0;
         wr_len_ff     <= '0;
         read_left_ff  <= '0;
         read_len_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ring_clear) begin
            write_pos_ff  <= '0;
            commit_pos_ff <= '0;
            read_pos_ff   <= '0;
            used_ff       <= '0;
            write_left_ff <= '0;
            wr_len_ff     <= '0;
            read_left_ff  <= '0;
            read_len_ff   <= '0;
         end else begin
            write_pos_ff  <= write_pos_in;
            commit_pos_ff <= commit_pos_in;
            read_pos_ff   <= read_pos_in;
            used_ff       <= used_in;
            write_left_ff <= write_left_in;
            wr_len_ff     <= wr_len_in;
            read_left_ff  <= read_left_in;
            read_len_ff   <= read_len_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_data_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= ring_mem[mem_raddr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[rtl/core/length_prefixed_record_ring_core.sv]
// Length-prefixed record ring: a byte ring of variable-length records, each
// stored behind a one-byte length. Requests enter a two-entry queue and are
// registered there before they reach the back end. Start, data and unused-kind
// requests finish in the idle state, so writes stream at one per cycle while
// responses are taken. A read uses the registered read port of the ring memory
// (header fetch, then data fetch at a record header) and holds off new requests
// until done. Writing ring_bytes empties the ring and drops any open record.
// Top level; instantiates lprr_front, lprr_queue and lprr_back, uses lprr_pkg.
module length_prefixed_record_ring_core
   import lprr_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEF
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data,
   input  logic            psel,
   input  logic            penable,
   input  logic            pwrite,
   input  logic [2:0]      paddr,
   input  logic [31:0]     pwdata,
   output logic [31:0]     prdata,
   output logic            pready
);

   localparam int POS_W      = $clog2(RING_DEPTH);
   localparam int SIZE_W     = POS_W + 1;
   localparam int CMP_W      = (SIZE_W > RING_BYTES_W) ? SIZE_W : RING_BYTES_W;
   localparam int RESET_SIZE = (RING_DEPTH < 4096) ? RING_DEPTH : 4096;

   logic                    log_enable_ff, log_enable_in;
   logic [RING_BYTES_W-1:0] ring_bytes_ff, ring_bytes_in;
   logic [SIZE_W-1:0]       ring_size_ff,  ring_size_in;
   logic [CMP_W-1:0]        size_raw;
   logic                    cfg_write;
   logic                    ring_clear;
   logic                    push_valid, push_ready;
   logic                    pop_valid, pop_ready;
   queue_entry_type         push_entry, pop_entry;

   assign pready     = 1'b1;
   assign cfg_write  = psel && penable && pwrite;
   assign ring_clear = cfg_write && (paddr[2] == ADDR_RING_BYTES[2]);
   assign size_raw   = CMP_W'(pwdata[RING_BYTES_W-1:0]);

   always_comb begin
      log_enable_in = log_enable_ff;
      ring_bytes_in = ring_bytes_ff;
      ring_size_in  = ring_size_ff;
      if (cfg_write && paddr[2] == ADDR_LOG_ENABLE[2]) begin
         log_enable_in = pwdata[0];
      end
      if (ring_clear) begin
         ring_bytes_in = pwdata[RING_BYTES_W-1:0];
         if (size_raw < CMP_W'(RING_MIN)) begin
            ring_size_in = SIZE_W'(RING_MIN);
         end else if (size_raw > CMP_W'(RING_DEPTH)) begin
            ring_size_in = SIZE_W'(RING_DEPTH);
         end else begin
            ring_size_in = size_raw[SIZE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         log_enable_ff <= 1'b1;
         ring_bytes_ff <= RING_BYTES_RESET;
         ring_size_ff  <= SIZE_W'(RESET_SIZE);
      end else begin
         log_enable_ff <= log_enable_in;
         ring_bytes_ff <= ring_bytes_in;
         ring_size_ff  <= ring_size_in;
      end
   end

   always_comb begin
      if (paddr[2] == ADDR_RING_BYTES[2]) begin
         prdata = 32'(ring_bytes_ff);
      end else begin
         prdata = 32'(log_enable_ff);
      end
   end

   lprr_front u_front (
      .req_data   (req_data),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   lprr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   lprr_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .log_enable (log_enable_ff),
      .ring_size  (ring_size_ff),
      .ring_clear (ring_clear),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

[rtl/core/lprr_checker.sv]
// Port-level checks for the record ring core, bound to the top level.
// Depends on lprr_pkg and length_prefixed_record_ring_core.
module lprr_checker
   import lprr_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_OK |->
         rsp_data.byte_out == 8'd0 && rsp_data.record_len == 8'd0 && !rsp_data.last)
      else $error("error response carries record data");

   a_write_no_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_OK && rsp_data.record_len == 8'd0 |->
         rsp_data.byte_out == 8'd0)
      else $error("byte returned without a record length");

endmodule

bind length_prefixed_record_ring_core lprr_checker u_lprr_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
